// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the factorizer datapath rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property on the rising edge, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in this cycle, consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pftd_pkg.sv
// ----------------------------------------------------------------------------
// pftd_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package pftd_pkg;

	localparam int TABLE_DEPTH = 8192;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int NUM_W       = 32;
	localparam int PRIME_W     = 16;
	localparam int EXP_W       = 5;
	localparam int STATUS_W    = 2;
	localparam int MAX_RESULTS = 9;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
	localparam int DIV_CNT_W   = $clog2(NUM_W);

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_FACTOR = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ONE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic wr;          // table write from a load transfer
		logic start;       // capture number, clear walk state
		logic rd;          // read table entry at walk index
		logic sq_load;     // register prime squared
		logic skip;        // advance walk index
		logic div_start;   // launch a division
		logic expo_clr;    // clear exponent
		logic div_accept;  // residue takes quotient, exponent counts up
		logic add;         // new result (prime or residue)
		logic add_resid;   // new result is the leftover residue
		logic flush;       // move pending result out, marked last
		logic special;     // one/zero result
	} pftd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic resid_zero;
		logic resid_one;
		logic idx_end;
		logic prime_small;
		logic sq_gt;
		logic div_done;
		logic rem_zero;
		logic expo_nz;
		logic add_blocked;
		logic out_free;
	} pftd_sts_t;

endpackage

// File: hw/rtl/pftd_divider.sv
// ----------------------------------------------------------------------------
// pftd_divider
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pftd_divider
	import pftd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   dividend,
	input  logic [PRIME_W-1:0] divisor,
	output logic               busy,
	output logic               done,
	output logic [NUM_W-1:0]   quotient,
	output logic [PRIME_W-1:0] remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     quo_q;
	logic [PRIME_W-1:0]   rem_q;
	logic [PRIME_W-1:0]   dsr_q;
	logic [PRIME_W:0]     trial;
	logic                 fits;
	logic                 last_bit;

	assign trial    = {rem_q, quo_q[NUM_W-1]};
	assign fits     = trial >= {1'b0, dsr_q};
	assign last_bit = cnt_q == DIV_CNT_W'(NUM_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// one-cycle pulse after the final quotient bit
			done_q <= !start && busy_q && last_bit;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_bit)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? PRIME_W'(trial - {1'b0, dsr_q}) : trial[PRIME_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: hw/rtl/pftd_datapath.sv
// ----------------------------------------------------------------------------
// pftd_datapath
// prime table, residue, walk index, divider and result registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pftd_datapath
	import pftd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  pftd_cmd_t           cmd,
	output pftd_sts_t           sts,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	input  logic [IDX_W-1:0]    table_index,
	input  logic [PRIME_W-1:0]  prime_value,
	input  logic [NUM_W-1:0]    number,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [NUM_W-1:0]    factor,
	output logic [EXP_W-1:0]    exponent,
	output logic                last,
	output logic [STATUS_W-1:0] status
);

	logic [PRIME_W-1:0]   table_mem [TABLE_DEPTH];
	logic [PRIME_W-1:0]   rd_q;
	logic [CNT_W-1:0]     primes_in_use_q;
	logic [CNT_W-1:0]     limit_q;
	logic [CNT_W-1:0]     idx_q;
	logic [NUM_W-1:0]     resid_q;
	logic [NUM_W-1:0]     sq_q;
	logic [EXP_W-1:0]     expo_q;
	logic                 pend_valid_q;
	logic [NUM_W-1:0]     pend_factor_q;
	logic [EXP_W-1:0]     pend_expo_q;
	logic [RES_CNT_W-1:0] count_q;
	logic                 out_valid_q;
	logic [NUM_W-1:0]     factor_q;
	logic [EXP_W-1:0]     exponent_q;
	logic                 last_q;
	logic [STATUS_W-1:0]  status_q;

	logic                 div_busy;
	logic                 div_done;
	logic [NUM_W-1:0]     div_quo;
	logic [PRIME_W-1:0]   div_rem;
	logic [NUM_W-1:0]     div_dividend;
	logic                 out_free;
	logic                 room;
	logic                 add_go;
	logic                 out_load;
	logic [NUM_W-1:0]     new_factor;
	logic [EXP_W-1:0]     new_expo;

	// repeated division chains on the quotient just produced
	assign div_dividend = cmd.div_accept ? div_quo : resid_q;

	pftd_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (rd_q),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign out_free   = !out_valid_q || out_ready;
	assign room       = count_q < RES_CNT_W'(MAX_RESULTS);
	assign add_go     = cmd.add && room;
	assign out_load   = (add_go && pend_valid_q) || cmd.flush || cmd.special;
	assign new_factor = cmd.add_resid ? resid_q : NUM_W'(rd_q);
	assign new_expo   = cmd.add_resid ? EXP_W'(1) : expo_q;

	always_comb begin
		sts.resid_zero  = resid_q == '0;
		sts.resid_one   = resid_q == NUM_W'(1);
		sts.idx_end     = idx_q >= limit_q;
		sts.prime_small = rd_q < PRIME_W'(2);
		sts.sq_gt       = sq_q > resid_q;
		sts.div_done    = div_done;
		sts.rem_zero    = div_rem == '0;
		sts.expo_nz     = expo_q != '0;
		sts.add_blocked = room && pend_valid_q && !out_free;
		sts.out_free    = out_free;
	end

	// table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr)
			table_mem[table_index] <= prime_value;
		if (cmd.rd)
			rd_q <= table_mem[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primes_in_use_q <= '0;
			pend_valid_q    <= 1'b0;
			count_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we)
				primes_in_use_q <= cfg_wdata;
			if (cmd.start) begin
				pend_valid_q <= 1'b0;
				count_q      <= '0;
			end else if (add_go) begin
				pend_valid_q <= 1'b1;
				count_q      <= count_q + 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			resid_q <= number;
			idx_q   <= '0;
			limit_q <= (primes_in_use_q > CNT_W'(TABLE_DEPTH)) ?
				CNT_W'(TABLE_DEPTH) : primes_in_use_q;
		end
		if (cmd.skip)
			idx_q <= idx_q + 1'b1;
		if (cmd.sq_load)
			sq_q <= NUM_W'(rd_q) * NUM_W'(rd_q);
		if (cmd.expo_clr)
			expo_q <= '0;
		if (cmd.div_accept) begin
			resid_q <= div_quo;
			if (expo_q != '1)
				expo_q <= expo_q + 1'b1;
		end
		if (add_go) begin
			pend_factor_q <= new_factor;
			pend_expo_q   <= new_expo;
		end
		if (cmd.special) begin
			factor_q   <= '0;
			exponent_q <= '0;
			last_q     <= 1'b1;
			status_q   <= (resid_q == '0) ? STATUS_ZERO : STATUS_ONE;
		end else if (out_load) begin
			factor_q   <= pend_factor_q;
			exponent_q <= pend_expo_q;
			last_q     <= cmd.flush;
			status_q   <= STATUS_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign factor    = factor_q;
	assign exponent  = exponent_q;
	assign last      = last_q;
	assign status    = status_q;

	`ASSERT_CLK(a_count_max, count_q <= RES_CNT_W'(MAX_RESULTS), "result count overflow")
	`ASSERT_CLK(a_pend_count, !pend_valid_q || count_q != '0, "pending result without count")
	`ASSERT_CLK(a_div_idle, !cmd.div_start || !div_busy, "division launched while busy")
	`ASSERT_NEXT(a_flush_last, cmd.flush && out_free, out_valid_q && last_q,
		"flush did not present a last result")

endmodule

// File: hw/rtl/pftd_ctrl.sv
// ----------------------------------------------------------------------------
// pftd_ctrl
// sequencer for table loads and the trial-division walk
// ----------------------------------------------------------------------------
module pftd_ctrl
	import pftd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      opcode,
	input  pftd_sts_t sts,
	output pftd_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SPEC,
		S_LOOP,
		S_PRIME,
		S_SQ,
		S_DIV,
		S_EMIT,
		S_FINAL,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && opcode == OP_LOAD) begin
					cmd.wr = 1'b1;
				end else if (accept) begin
					cmd.start = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = (sts.resid_zero || sts.resid_one) ? S_SPEC : S_LOOP;
			end
			S_SPEC: begin
				if (sts.out_free) begin
					cmd.special = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_LOOP: begin
				if (sts.idx_end || sts.resid_one) begin
					state_d = S_FINAL;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_PRIME;
				end
			end
			S_PRIME: begin
				if (sts.prime_small) begin
					cmd.skip = 1'b1;
					state_d  = S_LOOP;
				end else begin
					cmd.sq_load = 1'b1;
					state_d     = S_SQ;
				end
			end
			S_SQ: begin
				if (sts.sq_gt) begin
					state_d = S_FINAL;
				end else begin
					cmd.div_start = 1'b1;
					cmd.expo_clr  = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done && sts.rem_zero) begin
					cmd.div_accept = 1'b1;
					cmd.div_start  = 1'b1;
				end else if (sts.div_done && sts.expo_nz) begin
					state_d = S_EMIT;
				end else if (sts.div_done) begin
					cmd.skip = 1'b1;
					state_d  = S_LOOP;
				end
			end
			S_EMIT: begin
				if (!sts.add_blocked) begin
					cmd.add  = 1'b1;
					cmd.skip = 1'b1;
					state_d  = S_LOOP;
				end
			end
			S_FINAL: begin
				if (sts.resid_one) begin
					state_d = S_FLUSH;
				end else if (!sts.add_blocked) begin
					cmd.add       = 1'b1;
					cmd.add_resid = 1'b1;
					state_d       = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: hw/rtl/prime_factorization_trial_division.sv
// ----------------------------------------------------------------------------
// prime_factorization_trial_division
// trial-division factorizer over a loadable table of ascending primes
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid / in_ready    | opcode table_index
//           |           |                        | prime_value number
//   out     | output    | out_valid / out_ready  | factor exponent last status
//   cfg     | input     | cfg_we (no wait)       | cfg_wdata = primes_in_use
//
// a load transfer writes one table entry and leaves the input ready. a factor
// transfer walks the table: each entry of two or more is squared and, unless
// the square exceeds the residue, divided into it, one more division per power
// of the prime found; the restoring divider makes one quotient bit per cycle.
// reset (arst_n, asynchronous) clears the controller, the result count and
// primes_in_use; the prime table holds nothing until loaded and needs no
// clearing pass. a full output register only stalls the walk when a new
// result must move out; the input is taken again once the last result is
// in the output register.
// ----------------------------------------------------------------------------
module prime_factorization_trial_division
	import pftd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	// input items
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic [IDX_W-1:0]    table_index,
	input  logic [PRIME_W-1:0]  prime_value,
	input  logic [NUM_W-1:0]    number,
	// result items
	output logic                out_valid,
	input  logic                out_ready,
	output logic [NUM_W-1:0]    factor,
	output logic [EXP_W-1:0]    exponent,
	output logic                last,
	output logic [STATUS_W-1:0] status
);

	// command and status between sequencer and datapath
	pftd_cmd_t cmd;
	pftd_sts_t sts;

	// sequencer: loads, walk over table entries, result ordering
	pftd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: table memory, residue, divider, pending and output results
	pftd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.table_index (table_index),
		.prime_value (prime_value),
		.number      (number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.factor      (factor),
		.exponent    (exponent),
		.last        (last),
		.status      (status)
	);

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the trial-division prime factorizer
//
// items are queued by the stimulus sequence and driven on the input channel;
// every accepted transfer goes through a local copy of the prime table and
// the walk, and the results it predicts are compared in order with what the
// block hands out. both channels idle at random, the receiver stalls once for
// a long stretch, and the table length runs from empty up to past full depth.
// ----------------------------------------------------------------------------
module tb_top;
	import pftd_pkg::*;

	localparam int          IDLE_PCT        = 37;
	localparam int          HOLD_CYCLES     = 3000;
	localparam int          DRAIN_CYCLES    = 40;
	// above the longest walk here and the long hold-off
	localparam int          WATCHDOG_LIMIT  = 20_000;
	localparam int          ITEMS_PER_PHASE = 7;
	localparam int          MAX_REPORTS     = 200;
	localparam int          PRIME_LIMIT     = 65536;
	localparam int unsigned EXP_MAX         = (1 << EXP_W) - 1;
	localparam int unsigned CNT_MAX         = (1 << CNT_W) - 1;

	typedef struct packed {
		logic [NUM_W-1:0]    fac;
		logic [EXP_W-1:0]    expo;
		logic                fin;
		logic [STATUS_W-1:0] stat;
	} factor_rec_t;

	typedef struct packed {
		logic               op;
		logic [IDX_W-1:0]   idx;
		logic [PRIME_W-1:0] val;
		logic [NUM_W-1:0]   num;
	} pf_req_t;

	// dut ports, the driven inputs known from time zero
	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                cfg_we      = 1'b0;
	logic [CNT_W-1:0]    cfg_wdata   = '0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic                opcode      = OP_LOAD;
	logic [IDX_W-1:0]    table_index = '0;
	logic [PRIME_W-1:0]  prime_value = '0;
	logic [NUM_W-1:0]    number      = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [NUM_W-1:0]    factor;
	logic [EXP_W-1:0]    exponent;
	logic                last;
	logic [STATUS_W-1:0] status;

	// mirror of the block state
	logic [PRIME_W-1:0]  prime_mirror [TABLE_DEPTH];
	logic [CNT_W-1:0]    primes_used = '0;

	pf_req_t             pending_reqs [$];
	factor_rec_t         expected_factors [$];
	int unsigned         prime_list [$];
	bit                  composite [PRIME_LIMIT];
	int unsigned         phase_sizes [7] = '{1, 10, 30, 0, 6, 3, 12};

	// bookkeeping
	int unsigned         reqs_queued  = 0;
	int unsigned         reqs_taken   = 0;
	int unsigned         results_seen = 0;
	int unsigned         cfg_writes   = 0;
	int unsigned         err_count    = 0;
	int unsigned         quiet_cycles = 0;
	logic                in_taken     = 1'b0;
	bit                  no_idle      = 1'b0;
	bit                  hold_armed   = 1'b0;
	bit                  hold_done    = 1'b0;
	int unsigned         hold_left    = 0;
	pf_req_t             next_req;
	factor_rec_t         got_rec;
	factor_rec_t         want_rec;

	prime_factorization_trial_division dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.table_index (table_index),
		.prime_value (prime_value),
		.number      (number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.factor      (factor),
		.exponent    (exponent),
		.last        (last),
		.status      (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic factor_rec_t make_rec(input logic [NUM_W-1:0] f,
			input logic [EXP_W-1:0] e, input logic l, input logic [STATUS_W-1:0] s);
		factor_rec_t r;
		r.fac  = f;
		r.expo = e;
		r.fin  = l;
		r.stat = s;
		return r;
	endfunction

	// table write, one/zero result or full trial-division walk for one accepted transfer
	task automatic trial_divide(input pf_req_t req);
		factor_rec_t found [$];
		logic [63:0] resid;
		logic [63:0] p;
		int unsigned walk_end;
		int unsigned mult;
		int unsigned sat;
		bit          stop;
		if (req.op == OP_LOAD) begin
			prime_mirror[req.idx] = req.val;
		end else if (req.num == 0) begin
			expected_factors = {expected_factors, make_rec('0, '0, 1'b1, STATUS_ZERO)};
		end else if (req.num == 1) begin
			expected_factors = {expected_factors, make_rec('0, '0, 1'b1, STATUS_ONE)};
		end else begin
			resid = 64'(req.num);
			walk_end = 32'(primes_used);
			if (walk_end > TABLE_DEPTH)
				walk_end = TABLE_DEPTH;
			stop = 1'b0;
			for (int unsigned i = 0; i < walk_end && resid != 1 && !stop; i++) begin
				p = 64'(prime_mirror[i]);
				// entries below two never divide anything out and are passed over
				if (p >= 2) begin
					if (p * p > resid) begin
						stop = 1'b1;
					end else begin
						mult = 0;
						while (resid % p == 0) begin
							resid = resid / p;
							mult++;
						end
						sat = (mult > EXP_MAX) ? EXP_MAX : mult;
						if (mult != 0 && found.size() < MAX_RESULTS)
							found = {found, make_rec(p[NUM_W-1:0], sat[EXP_W-1:0], 1'b0,
								STATUS_OK)};
					end
				end
			end
			// leftover residue, possibly composite when the table is short
			if (resid != 1 && found.size() < MAX_RESULTS)
				found = {found, make_rec(resid[NUM_W-1:0], EXP_W'(1), 1'b0, STATUS_OK)};
			found[found.size() - 1].fin = 1'b1;
			foreach (found[i])
				expected_factors = {expected_factors, found[i]};
		end
	endtask

	task automatic push_load(input int unsigned idx, input int unsigned val);
		pf_req_t r;
		r.op  = OP_LOAD;
		r.idx = idx[IDX_W-1:0];
		r.val = val[PRIME_W-1:0];
		r.num = $urandom();
		pending_reqs = {pending_reqs, r};
		reqs_queued++;
	endtask

	task automatic push_factor(input logic [NUM_W-1:0] n);
		pf_req_t r;
		r.op  = OP_FACTOR;
		r.idx = IDX_W'($urandom());
		r.val = PRIME_W'($urandom());
		r.num = n;
		pending_reqs = {pending_reqs, r};
		reqs_queued++;
	endtask

	// wait until every queued transfer is in and every result is out, then
	// give a just-accepted load time to settle
	task automatic quiesce();
		while (reqs_taken != reqs_queued || expected_factors.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_primes_used(input int unsigned v);
		@(negedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= v[CNT_W-1:0];
		primes_used = v[CNT_W-1:0];
		@(negedge clk);
		cfg_we      <= 1'b0;
		cfg_writes++;
		@(posedge clk);
	endtask

	// sender: a new transfer is offered only once the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
				next_req = pending_reqs.pop_front();
				in_valid    <= 1'b1;
				opcode      <= next_req.op;
				table_index <= next_req.idx;
				prime_value <= next_req.val;
				number      <= next_req.num;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random idling, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor: check results in order, predict from accepted transfers
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;

		if (arst_n && out_valid && out_ready) begin
			got_rec = make_rec(factor, exponent, last, status);
			if (expected_factors.size() == 0) begin
				if (err_count < MAX_REPORTS)
					$display("%0t: nothing expected, actual f=%0d e=%0d l=%0b s=%0d",
						$time, got_rec.fac, got_rec.expo, got_rec.fin, got_rec.stat);
				err_count++;
			end else begin
				want_rec = expected_factors.pop_front();
				if (got_rec !== want_rec) begin
					if (err_count < MAX_REPORTS)
						$display("%0t: expected f=%0d e=%0d l=%0b s=%0d, %s%0d e=%0d l=%0b s=%0d",
							$time, want_rec.fac, want_rec.expo, want_rec.fin, want_rec.stat,
							"actual f=", got_rec.fac, got_rec.expo, got_rec.fin,
							got_rec.stat);
					err_count++;
				end
				results_seen++;
			end
		end

		if (arst_n && in_valid && in_ready) begin
			next_req.op  = opcode;
			next_req.idx = table_index;
			next_req.val = prime_value;
			next_req.num = number;
			trial_divide(next_req);
			reqs_taken++;
		end
	end

	// watchdog on cycles with no transfer on either channel
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [63:0] v;
		int unsigned k;
		int unsigned pool;
		int unsigned j;
		int unsigned e;
		int unsigned sel;
		int unsigned idx;

		// sieve the primes below 2^16 for table contents and stimulus
		for (int unsigned i = 2; i < PRIME_LIMIT; i++) begin
			if (!composite[i]) begin
				prime_list = {prime_list, i};
				if (i < 256)
					for (int unsigned m = i * i; m < PRIME_LIMIT; m += i)
						composite[m] = 1'b1;
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table length is zero out of reset: every number comes back whole
		push_factor(0);
		push_factor(1);
		push_factor(2);
		push_factor(32'hFFFF_FFFF);
		push_factor(32'h8000_0000);
		quiesce();

		// short table with skipped entries and a composite head entry, so that
		// a number has more factors than there are result slots
		set_primes_used(12);
		push_load(0, 1);
		push_load(1, 4);
		push_load(2, 0);
		push_load(3, 2);
		push_load(4, 3);
		push_load(5, 5);
		push_load(6, 7);
		push_load(7, 11);
		push_load(8, 13);
		push_load(9, 17);
		push_load(10, 19);
		push_load(11, 23);
		push_factor(32'd892371480);
		push_factor(32'h8000_0000);
		push_factor(32'd223092870);
		quiesce();

		// length beyond the table depth: the walk is clamped, and these numbers
		// all finish inside the loaded entries
		set_primes_used(CNT_MAX);
		push_factor(0);
		push_factor(1);
		push_factor(2);
		push_factor(32'h8000_0000);
		push_factor(32'd223092870);
		push_factor(32'd529);
		quiesce();

		// random phases over several short table lengths
		for (int ph = 0; ph < 7; ph++) begin
			k = phase_sizes[ph];
			no_idle = (ph == 1);
			set_primes_used(k);
			for (int unsigned i = 0; i < k; i++)
				push_load(i, prime_list[i]);
			pool = (k < 10) ? 10 : ((k > 40) ? 40 : k);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 15) begin
					// mostly stray loads past the walked part, some that spoil it
					if (k == 0 || $urandom_range(99) < 70)
						idx = $urandom_range(TABLE_DEPTH - 1, k);
					else
						idx = $urandom_range(k - 1, 0);
					push_load(idx, $urandom());
				end else begin
					sel = $urandom_range(99);
					if (sel < 6) begin
						v = 64'($urandom_range(1, 0));
					end else if (sel < 20) begin
						v = 64'($urandom());
					end else begin
						// smooth number over small primes, sometimes with a big cofactor
						v = 1;
						repeat ($urandom_range(6, 1)) begin
							j = $urandom_range(pool - 1, 0);
							e = $urandom_range(4, 1);
							repeat (e)
								if (v * prime_list[j] <= 64'hFFFF_FFFF)
									v = v * prime_list[j];
						end
						if ($urandom_range(1, 0))
							v = v * $urandom_range(32'(64'hFFFF_FFFF / v), 1);
					end
					push_factor(v[NUM_W-1:0]);
				end
			end
			if (ph == 2)
				hold_armed = 1'b1;
			quiesce();
		end
		no_idle = 1'b0;

		$display("covered %0d input transfers, %0d results checked, %0d table length writes",
			reqs_taken, results_seen, cfg_writes);
		$display("table lengths from empty to past full depth, one and zero, truncated results");
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
